// ===== design/cmfa_pkg.sv =====
// Package: shared types and constants of the cube map face address unit.
`default_nettype none
package cmfa_pkg;
  localparam int NumCells = 32;
  localparam logic [30:0] RadiusReset = 31'd65536;

  localparam logic [2:0] FaceXNeg = 3'd0;
  localparam logic [2:0] FaceXPos = 3'd1;
  localparam logic [2:0] FaceYNeg = 3'd2;
  localparam logic [2:0] FaceYPos = 3'd3;
  localparam logic [2:0] FaceZNeg = 3'd4;
  localparam logic [2:0] FaceZPos = 3'd5;

  typedef struct packed {
    logic [2:0]  face;
    logic        zero;
    logic [63:0] sq;
    logic [35:0] srem;
    logic [31:0] root;
    logic [32:0] div;
    logic [31:0] du;
    logic [31:0] dv;
    logic [32:0] ru;
    logic [32:0] rv;
    logic [16:0] qu;
    logic [16:0] qv;
  } cell_t;
endpackage
`default_nettype wire

// ===== design/cmfa_prep.sv =====
// Front stages: face selection, squares, dividend setup.
`default_nettype none
module cmfa_prep (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic signed [31:0]    x_i,
  input  logic signed [31:0]    y_i,
  input  logic signed [31:0]    z_i,
  output logic                  valid_o,
  output cmfa_pkg::cell_t       data_o
);
  import cmfa_pkg::*;

  logic [31:0] ax, ay, az;
  logic signed [32:0] xs, ys, zs;
  logic [2:0] face_d;
  logic [31:0] m_d;
  logic signed [32:0] a_d, b_d;

  logic v1_q, v2_q;
  logic [2:0] face_q;
  logic zero_q;
  logic [31:0] m_q;
  logic signed [32:0] a_q, b_q;
  logic [63:0] sqx_q, sqy_q, sqz_q;
  cell_t data_q, data_d;

  logic [33:0] su, sv;
  logic [49:0] nu, nv;

  always_comb begin
    ax = x_i[31] ? (~x_i + 32'd1) : x_i;
    ay = y_i[31] ? (~y_i + 32'd1) : y_i;
    az = z_i[31] ? (~z_i + 32'd1) : z_i;
    xs = {x_i[31], x_i};
    ys = {y_i[31], y_i};
    zs = {z_i[31], z_i};
    if (az >= ax && az >= ay) begin
      face_d = z_i[31] ? FaceZNeg : FaceZPos;
      m_d    = az;
      a_d    = z_i[31] ? -xs : xs;
      b_d    = -ys;
    end else if (ay >= ax) begin
      face_d = y_i[31] ? FaceYNeg : FaceYPos;
      m_d    = ay;
      a_d    = xs;
      b_d    = y_i[31] ? -zs : zs;
    end else begin
      face_d = x_i[31] ? FaceXNeg : FaceXPos;
      m_d    = ax;
      a_d    = x_i[31] ? zs : -zs;
      b_d    = -ys;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      face_q <= face_d;
      zero_q <= (ax == 32'd0) && (ay == 32'd0) && (az == 32'd0);
      m_q    <= m_d;
      a_q    <= a_d;
      b_q    <= b_d;
      sqx_q  <= {32'd0, ax} * {32'd0, ax};
      sqy_q  <= {32'd0, ay} * {32'd0, ay};
      sqz_q  <= {32'd0, az} * {32'd0, az};
      data_q <= data_d;
    end
  end

  always_comb begin
    su = {a_q[32], a_q} + {2'b00, m_q};
    sv = {b_q[32], b_q} + {2'b00, m_q};
    nu = {1'b0, su[32:0], 16'd0} + {18'd0, m_q};
    nv = {1'b0, sv[32:0], 16'd0} + {18'd0, m_q};
    data_d.face = face_q;
    data_d.zero = zero_q;
    data_d.sq   = sqx_q + sqy_q + sqz_q;
    data_d.srem = 36'd0;
    data_d.root = 32'd0;
    data_d.div  = {m_q, 1'b0};
    data_d.du   = nu[31:0];
    data_d.dv   = nv[31:0];
    data_d.ru   = {15'd0, nu[49:32]};
    data_d.rv   = {15'd0, nv[49:32]};
    data_d.qu   = 17'd0;
    data_d.qv   = 17'd0;
  end

  assign valid_o = v2_q;
  assign data_o  = data_q;
endmodule
`default_nettype wire

// ===== design/cmfa_cell.sv =====
// One cell: one root bit and one quotient bit for u and v.
`default_nettype none
module cmfa_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  cmfa_pkg::cell_t data_i,
  output logic            valid_o,
  output cmfa_pkg::cell_t data_o
);
  import cmfa_pkg::*;

  logic valid_q;
  cell_t data_q, data_d;
  logic [35:0] rs, trial;
  logic [33:0] us, vs, dd;

  always_comb begin
    data_d = data_i;
    rs     = {data_i.srem[33:0], data_i.sq[63:62]};
    trial  = {2'b00, data_i.root, 2'b01};
    data_d.sq = {data_i.sq[61:0], 2'b00};
    if (rs >= trial) begin
      data_d.srem = rs - trial;
      data_d.root = {data_i.root[30:0], 1'b1};
    end else begin
      data_d.srem = rs;
      data_d.root = {data_i.root[30:0], 1'b0};
    end
    dd = {1'b0, data_i.div};
    us = {data_i.ru, data_i.du[31]};
    vs = {data_i.rv, data_i.dv[31]};
    data_d.du = {data_i.du[30:0], 1'b0};
    data_d.dv = {data_i.dv[30:0], 1'b0};
    if (us >= dd) begin
      data_d.ru = 33'(us - dd);
      data_d.qu = {data_i.qu[15:0], 1'b1};
    end else begin
      data_d.ru = us[32:0];
      data_d.qu = {data_i.qu[15:0], 1'b0};
    end
    if (vs >= dd) begin
      data_d.rv = 33'(vs - dd);
      data_d.qv = {data_i.qv[15:0], 1'b1};
    end else begin
      data_d.rv = vs[32:0];
      data_d.qv = {data_i.qv[15:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule
`default_nettype wire

// ===== design/cube_map_face_address_unit.sv =====
// Top level: cube map face address unit, prep stages, cell chain, output register.
//
//   channel | direction | words
//   in      | in        | point_x_i, point_y_i, point_z_i
//   out     | out       | face_o, face_u_o, face_v_o, height_o, zero_vector_o
//   cfg     | in        | cfg_sphere_radius_i
//
// One word per cycle unless the output stalls (2 prep stages, 32 cells, output register).
// The 32-cell chain sets the latency: each cell makes one root bit and one quotient bit.
// Reset clears all valid bits and loads the radius with 1.0.
// A stalled output holds the whole pipeline; in_ready_o follows out_ready_i then.
`default_nettype none
module cube_map_face_address_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         face_o,
  output logic [16:0]        face_u_o,
  output logic [16:0]        face_v_o,
  output logic signed [32:0] height_o,
  output logic               zero_vector_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [30:0]        cfg_sphere_radius_i
);
  import cmfa_pkg::*;

  logic en;
  logic [30:0] radius_q;
  logic [NumCells:0] vchain;
  cell_t dchain [NumCells+1];
  logic out_valid_q;
  cell_t last;
  logic [2:0]  face_q;
  logic [16:0] u_q, v_q;
  logic [32:0] h_q;
  logic        zero_q;

  assign en = !out_valid_q || out_ready_i;
  assign in_ready_o = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RadiusReset;
    end else if (cfg_valid_i) begin
      radius_q <= cfg_sphere_radius_i;
    end
  end

  cmfa_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .x_i     (point_x_i),
    .y_i     (point_y_i),
    .z_i     (point_z_i),
    .valid_o (vchain[0]),
    .data_o  (dchain[0])
  );

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    cmfa_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vchain[i]),
      .data_i  (dchain[i]),
      .valid_o (vchain[i+1]),
      .data_o  (dchain[i+1])
    );
  end

  assign last = dchain[NumCells];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vchain[NumCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      zero_q <= last.zero;
      if (last.zero) begin
        face_q <= 3'd0;
        u_q    <= 17'd0;
        v_q    <= 17'd0;
        h_q    <= 33'd0;
      end else begin
        face_q <= last.face;
        u_q    <= last.qu;
        v_q    <= last.qv;
        h_q    <= {1'b0, last.root} - {2'b00, radius_q};
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign face_o        = face_q;
  assign face_u_o      = u_q;
  assign face_v_o      = v_q;
  assign height_o      = h_q;
  assign zero_vector_o = zero_q;
endmodule
`default_nettype wire

// ===== sim/cube_map_face_address_unit_tb.sv =====
// Testbench: directed and randomized stream check of the cube map face address unit against a predictor.
`timescale 1ns / 100ps
module cube_map_face_address_unit_tb;
  import cmfa_pkg::*;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  typedef struct packed {
    logic [2:0]         face;
    logic [16:0]        u;
    logic [16:0]        v;
    logic signed [32:0] height;
    logic               zero;
  } addr_t;

  localparam int Latency = 35;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] px = '0, py = '0, pz = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         face;
  logic [16:0]        face_u, face_v;
  logic signed [32:0] height;
  logic               zero_vector;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [30:0]        cfg_radius = '0;

  cube_map_face_address_unit DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .point_x_i(px), .point_y_i(py), .point_z_i(pz),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .face_o(face), .face_u_o(face_u), .face_v_o(face_v),
    .height_o(height), .zero_vector_o(zero_vector),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_sphere_radius_i(cfg_radius)
  );

  point_t     pending_points[$];
  addr_t      expected_addrs[$];
  logic [30:0] radius_q = RadiusReset;
  int          errors = 0;
  bit          quiet = 1'b0;
  bit          hold_send = 1'b0;
  int          in_gap = 0, out_gap = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root[31:0];
  endfunction

  function automatic logic [16:0] face_coord(input logic signed [33:0] c,
                                             input logic [32:0] m);
    logic [63:0] num;
    num = ({30'd0, 34'(c + $signed({1'b0, m}))} << 16) + m;
    return 17'(num / ({31'd0, m} << 1));
  endfunction

  function automatic addr_t locate_on_cube(input point_t p);
    addr_t r;
    logic signed [33:0] x, y, z, a, b;
    logic [32:0] ax, ay, az, m;
    logic [63:0] sq;
    x = p.x; y = p.y; z = p.z;
    ax = x < 0 ? 33'(-x) : 33'(x);
    ay = y < 0 ? 33'(-y) : 33'(y);
    az = z < 0 ? 33'(-z) : 33'(z);
    r = '0;
    if (ax == 0 && ay == 0 && az == 0) begin
      r.zero = 1'b1;
      return r;
    end
    if (az >= ax && az >= ay) begin
      r.face = z < 0 ? FaceZNeg : FaceZPos;
      m = az; a = z < 0 ? -x : x; b = -y;
    end else if (ay >= ax) begin
      r.face = y < 0 ? FaceYNeg : FaceYPos;
      m = ay; a = x; b = y < 0 ? -z : z;
    end else begin
      r.face = x < 0 ? FaceXNeg : FaceXPos;
      m = ax; a = x < 0 ? z : -z; b = -y;
    end
    sq = {31'd0, ax} * {31'd0, ax} + {31'd0, ay} * {31'd0, ay} + {31'd0, az} * {31'd0, az};
    r.u = face_coord(a, m);
    r.v = face_coord(b, m);
    r.height = $signed({1'b0, floor_sqrt(sq)}) - $signed({2'b0, radius_q});
    return r;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(int'($urandom_range(0, 8)) - 4);
      3: return 32'(int'($urandom_range(0, 'h4_0000)) - 'h2_0000);
      default: return $urandom;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      expected_addrs.push_back(locate_on_cube(pending_points.pop_front()));
    end
    if (!(in_valid && !in_ready)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 19) == 0) begin
        in_gap <= $urandom_range(0, 16);
        in_valid <= 1'b0;
      end else if (!hold_send && pending_points.size() > 0) begin
        in_valid <= 1'b1;
        px <= pending_points[0].x;
        py <= pending_points[0].y;
        pz <= pending_points[0].z;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    addr_t exp_a;
    if (out_valid && out_ready) begin
      if (expected_addrs.size() == 0) begin
        $display("%0t: unexpected word face=%0d u=%0d v=%0d h=%0d z=%0b", $time,
                 face, face_u, face_v, height, zero_vector);
        errors++;
      end else begin
        exp_a = expected_addrs.pop_front();
        if (face !== exp_a.face) begin
          $display("%0t: face exp %0d got %0d", $time, exp_a.face, face); errors++;
        end
        if (face_u !== exp_a.u) begin
          $display("%0t: face_u exp %0d got %0d", $time, exp_a.u, face_u); errors++;
        end
        if (face_v !== exp_a.v) begin
          $display("%0t: face_v exp %0d got %0d", $time, exp_a.v, face_v); errors++;
        end
        if (height !== exp_a.height) begin
          $display("%0t: height exp %0d got %0d", $time, exp_a.height, height); errors++;
        end
        if (zero_vector !== exp_a.zero) begin
          $display("%0t: zero_vector exp %0b got %0b", $time, exp_a.zero, zero_vector);
          errors++;
        end
      end
    end
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 19) == 0) begin
      out_gap <= $urandom_range(0, 16);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic drain();
    while (pending_points.size() != 0 || in_valid || expected_addrs.size() != 0)
      @(posedge clk);
    repeat (Latency + 5) @(posedge clk);
  endtask

  task automatic write_radius(input logic [30:0] r);
    cfg_valid <= 1'b1;
    cfg_radius <= r;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    radius_q = r;
    cfg_valid <= 1'b0;
  endtask

  task automatic add_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    point_t p;
    p.x = x; p.y = y; p.z = z;
    pending_points.push_back(p);
  endtask

  initial begin
    logic [30:0] radii[5];
    radii = '{31'd0, 31'h7fff_ffff, 31'd65536, 31'd12345678, 31'd1};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: zero, extremes, ties, each face, exact halves
    add_point(0, 0, 0);
    add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    add_point(32'h8000_0000, 32'h7fff_ffff, 0);
    add_point(32'h7fff_ffff, 32'h8000_0000, 1);
    add_point(5, 5, 0);
    add_point(5, -5, 0);
    add_point(-7, 3, 2);
    add_point(7, 3, 2);
    add_point(1, -7, 3);
    add_point(1, 7, -3);
    add_point(2, 3, -9);
    add_point(2, 3, 9);
    add_point(-9, 9, 9);
    add_point(1, 0, 0);
    add_point(-1, 0, 0);
    add_point(3, 1, 0);
    add_point(32'hffff_ffff, 32'hffff_ffff, 32'h0001_0000);
    add_point(32'h8000_0000, 0, 0);
    add_point(32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678);
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      write_radius(radii[ph]);
      // sender holds while each phase's points are queued, then is released
      hold_send = 1'b1;
      for (int i = 0; i < 350; i++) add_point(rand_coord(), rand_coord(), rand_coord());
      repeat ($urandom_range(1, 20)) @(posedge clk);
      hold_send = 1'b0;
      if (ph == 4) quiet = 1'b1;
      drain();
    end
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end
endmodule
